// File: hdl/assert_macros.svh
// Assertion helpers for the directivity lookup block.
// All properties are sampled on i_clk and are off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define DLU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define DLU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/dlu_pkg.sv
// ----------------------------------------------------------------------------
// dlu_pkg
// Constants, types and helpers shared by the directivity lookup block.
// ----------------------------------------------------------------------------
package dlu_pkg;

    localparam int NUM_BANDS_DEF = 8;
    localparam int MIN_STEP_DEG  = 5;
    localparam int MAX_STEP      = 90;
    localparam int AFB           = 6;      // angle fraction bits
    localparam int LEVEL_BITS    = 16;
    localparam int FULL_TURN     = 360;
    localparam int HALF_TURN     = 180;
    localparam int STEP_RESET    = 5;

    localparam int STEP_W = 7;
    localparam int BAND_W = 3;
    localparam int AZ_W   = 15;
    localparam int POL_W  = 14;
    localparam int ROW_W  = AZ_W - AFB;     // integer degrees of azimuth
    localparam int S_W    = STEP_W + AFB;   // step in fixed point
    localparam int D_W    = 2 * STEP_W;     // step squared

    localparam int GRID_ROWS = FULL_TURN / MIN_STEP_DEG;
    localparam int GRID_COLS = HALF_TURN / MIN_STEP_DEG + 1;
    localparam int BAND_SIZE = GRID_ROWS * GRID_COLS;

    localparam int PROD_W = 2 * S_W + LEVEL_BITS + 1;
    localparam int ACC_W  = PROD_W + 2;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    function automatic logic [STEP_W-1:0] step_clamp(input logic [STEP_W-1:0] v);
        logic [STEP_W-1:0] s;
        s = v;
        if (s < STEP_W'(MIN_STEP_DEG)) s = STEP_W'(MIN_STEP_DEG);
        if (s > STEP_W'(MAX_STEP)) s = STEP_W'(MAX_STEP);
        return s;
    endfunction

endpackage

// File: hdl/directivity_bilinear_lookup_top.sv
// ----------------------------------------------------------------------------
// directivity_bilinear_lookup_top
// Per-band attenuation grid with write and bilinear query transactions.
// ----------------------------------------------------------------------------
// One transaction at a time. A write runs the bit-serial angle divider, a
// row wrap step and a step for neighbors and the table write before the
// next acceptance. A query runs the same steps, then the four table reads
// and the shared multiply-accumulate (read, weight product, level product,
// add per corner), a setup step and the bit-serial divider by step squared,
// then loads the output register once the receiver does not stall a held
// result. A query that misses (out of range, bad or unwritten band) skips
// to the output register. The single table port and the two serial dividers
// set this sequence. angle_step is clamped to the range 5..90 when written.
module directivity_bilinear_lookup_top import dlu_pkg::*; #(
    parameter int NUM_BANDS = NUM_BANDS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_operation,
    input  logic [BAND_W-1:0]            i_band,
    input  logic [AZ_W-1:0]              i_azimuth,
    input  logic [POL_W-1:0]             i_polar,
    input  logic signed [LEVEL_BITS-1:0] i_level,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [LEVEL_BITS-1:0] o_result_level,
    output logic                         o_valid_res,
    output logic                         o_exact_hit,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [STEP_W-1:0]            i_cfg_data
);

    `include "assert_macros.svh"

    localparam int DEPTH  = NUM_BANDS * BAND_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(LEVEL_BITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_WRAP, ST_NEIGH, ST_MAC, ST_PREP, ST_QDIV, ST_FIN
    } t_state;

    typedef enum logic [1:0] {PH_READ, PH_MUL, PH_ACC} t_phase;

    t_state                        r_state;
    t_phase                        r_ph;
    logic [CNT_W-1:0]              r_cnt;
    logic [1:0]                    r_k;
    logic                          r_op;
    logic [BAND_W-1:0]             r_band;
    logic [AFB-1:0]                r_az_lo, r_pol_lo;
    logic signed [LEVEL_BITS-1:0]  r_lvl;
    logic                          r_inrng;
    logic [STEP_W-1:0]             r_step;
    logic [STEP_W-1:0]             r_ra, r_rp;
    logic [ROW_W-1:0]              r_qa, r_qp;
    logic [D_W-1:0]                r_d;
    logic [ROW_W-1:0]              r_r0, r_r1, r_c0, r_c1;
    logic                          r_ok;
    logic [2*S_W-1:0]              r_w;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic [D_W-1:0]                r_rem2;
    logic [LEVEL_BITS-1:0]         r_dq;
    logic [(1<<BAND_W)-1:0]        r_present;
    logic                          r_ovalid, r_vres, r_exact;
    logic signed [LEVEL_BITS-1:0]  r_res;

    logic [S_W-1:0]                s_val, fa, fp, wa, wp;
    logic [ROW_W-1:0]              row_sel, col_sel, r1;
    logic                          band_ok;
    logic [STEP_W:0]               ta, tp;
    logic                          ge_a, ge_p;
    logic [ROW_W+STEP_W-1:0]       row_prod, r1_prod;
    logic [D_W:0]                  t2;
    logic                          ge2;
    logic signed [ACC_W-1:0]       y_full;
    logic signed [PROD_W-1:0]      n_prod;
    t_mem_ctl                      mem_ctl;
    logic [ADDR_W-1:0]             mem_addr;
    logic signed [LEVEL_BITS-1:0]  mem_rdata;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [BAND_W-1:0] b,
                                                  input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] col);
        return ADDR_W'(32'(b) * BAND_SIZE + 32'(row) * GRID_COLS + 32'(col));
    endfunction

    always_comb begin
        s_val    = {r_step, AFB'(0)};
        fa       = {r_ra, r_az_lo};
        fp       = {r_rp, r_pol_lo};
        wa       = r_k[1] ? fa : s_val - fa;
        wp       = r_k[0] ? fp : s_val - fp;
        row_sel  = r_k[1] ? r_r1 : r_r0;
        col_sel  = r_k[0] ? r_c1 : r_c0;
        band_ok  = 32'(r_band) < NUM_BANDS;
        ta       = {r_ra, r_qa[ROW_W-1]};
        tp       = {r_rp, r_qp[ROW_W-1]};
        ge_a     = ta >= {1'b0, r_step};
        ge_p     = tp >= {1'b0, r_step};
        row_prod = r_qa * r_step;
        r1       = r_r0 + 1'b1;
        r1_prod  = r1 * r_step;
        t2       = {r_rem2, r_dq[LEVEL_BITS-1]};
        ge2      = t2 >= {1'b0, r_d};
        y_full   = (r_acc >>> (2 * AFB)) + (ACC_W'(r_d) << (LEVEL_BITS - 1));
        n_prod   = $signed({1'b0, r_w}) * mem_rdata;
        mem_ctl.we = (r_state == ST_NEIGH) && !r_op && r_inrng && band_ok;
        mem_ctl.re = (r_state == ST_MAC) && (r_ph == PH_READ);
        mem_addr   = (r_state == ST_MAC) ? addr_of(r_band, row_sel, col_sel)
                                         : addr_of(r_band, r_r0, r_c0);
    end

    dlu_table #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_table (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (r_lvl),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ph      <= PH_READ;
            r_cnt     <= '0;
            r_k       <= '0;
            r_step    <= step_clamp(STEP_W'(STEP_RESET));
            r_present <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_step <= step_clamp(i_cfg_data);
            end
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_op     <= i_operation;
                        r_band   <= i_band;
                        r_lvl    <= i_level;
                        r_az_lo  <= i_azimuth[AFB-1:0];
                        r_pol_lo <= i_polar[AFB-1:0];
                        r_qa     <= i_azimuth[AZ_W-1:AFB];
                        r_qp     <= ROW_W'(i_polar[POL_W-1:AFB]);
                        r_ra     <= '0;
                        r_rp     <= '0;
                        r_inrng  <= (32'(i_azimuth) <= (FULL_TURN << AFB)) &&
                                    (32'(i_polar) <= (HALF_TURN << AFB));
                        r_cnt    <= '0;
                        r_state  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // restoring division of integer degrees by the step
                    r_ra  <= ge_a ? STEP_W'(ta - {1'b0, r_step}) : ta[STEP_W-1:0];
                    r_rp  <= ge_p ? STEP_W'(tp - {1'b0, r_step}) : tp[STEP_W-1:0];
                    r_qa  <= {r_qa[ROW_W-2:0], ge_a};
                    r_qp  <= {r_qp[ROW_W-2:0], ge_p};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(ROW_W - 1)) begin
                        r_state <= ST_WRAP;
                    end
                end
                ST_WRAP: begin
                    r_r0 <= (row_prod < FULL_TURN && r_qa < GRID_ROWS) ? r_qa : '0;
                    r_c0 <= (r_qp >= GRID_COLS) ? ROW_W'(GRID_COLS - 1) : r_qp;
                    r_d  <= r_step * r_step;
                    r_state <= ST_NEIGH;
                end
                ST_NEIGH: begin
                    r_r1  <= (r1_prod < FULL_TURN && r1 < GRID_ROWS) ? r1 : '0;
                    r_c1  <= (r_c0 + 1'b1 >= GRID_COLS) ? r_c0 : r_c0 + 1'b1;
                    // start from half of S*S for round-half-up
                    r_acc <= ACC_W'(r_d) << (2 * AFB - 1);
                    r_ok  <= r_inrng && band_ok && r_present[r_band];
                    r_k   <= '0;
                    r_ph  <= PH_READ;
                    if (!r_op) begin
                        if (r_inrng && band_ok) begin
                            r_present[r_band] <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end else if (r_inrng && band_ok && r_present[r_band]) begin
                        r_state <= ST_MAC;
                    end else begin
                        r_state <= ST_FIN;
                    end
                end
                ST_MAC: begin
                    case (r_ph)
                        PH_READ: begin
                            r_w  <= wa * wp;
                            r_ph <= PH_MUL;
                        end
                        PH_MUL: begin
                            r_prod <= n_prod;
                            r_ph   <= PH_ACC;
                        end
                        PH_ACC: begin
                            r_acc <= r_acc + ACC_W'(r_prod);
                            r_ph  <= PH_READ;
                            r_k   <= r_k + 1'b1;
                            if (r_k == 2'd3) begin
                                r_state <= ST_PREP;
                            end
                        end
                        default: r_ph <= PH_READ;
                    endcase
                end
                ST_PREP: begin
                    // bias by 2^(L-1)*d so the floor division runs unsigned
                    r_rem2  <= y_full[LEVEL_BITS+D_W-1:LEVEL_BITS];
                    r_dq    <= y_full[LEVEL_BITS-1:0];
                    r_cnt   <= '0;
                    r_state <= ST_QDIV;
                end
                ST_QDIV: begin
                    r_rem2 <= ge2 ? D_W'(t2 - {1'b0, r_d}) : t2[D_W-1:0];
                    r_dq   <= {r_dq[LEVEL_BITS-2:0], ge2};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(LEVEL_BITS - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_res    <= r_ok ? $signed({~r_dq[LEVEL_BITS-1],
                                                    r_dq[LEVEL_BITS-2:0]}) : '0;
                        r_vres   <= r_ok;
                        r_exact  <= r_ok && (fa == '0) && (fp == '0);
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = r_ovalid;
    assign o_result_level = r_res;
    assign o_valid_res    = r_vres;
    assign o_exact_hit    = r_exact;
    assign o_cfg_ready    = 1'b1;

    `DLU_ASSERT_IMP(a_invalid_zero, o_valid && !o_valid_res, o_result_level == '0 && !o_exact_hit)
    `DLU_ASSERT_NXT(a_busy_after_accept, i_valid && !o_stall, o_stall)
    `DLU_ASSERT_IMP(a_step_range, 1'b1, r_step >= STEP_W'(MIN_STEP_DEG) && r_step <= STEP_W'(MAX_STEP))
    `DLU_ASSERT_IMP(a_mac_needs_ok, r_state == ST_MAC, r_ok && r_op)

endmodule

// File: hdl/dlu_table.sv
// ----------------------------------------------------------------------------
// dlu_table
// Single-port attenuation table, registered read data.
// ----------------------------------------------------------------------------
module dlu_table import dlu_pkg::*; #(
    parameter int DEPTH  = NUM_BANDS_DEF * BAND_SIZE,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  t_mem_ctl                     i_ctl,
    input  logic [ADDR_W-1:0]            i_addr,
    input  logic signed [LEVEL_BITS-1:0] i_wdata,
    output logic signed [LEVEL_BITS-1:0] o_rdata
);

    logic signed [LEVEL_BITS-1:0] mem [DEPTH];
    logic signed [LEVEL_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: dv/directivity_bilinear_lookup_checker.sv
// ----------------------------------------------------------------------------
// directivity_bilinear_lookup_checker
// Watches the item, result and step channels of the directivity lookup,
// keeps its own attenuation grid and predicts every query answer, then
// compares each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module directivity_bilinear_lookup_checker import dlu_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         o_stall,
    input  logic                         i_operation,
    input  logic [BAND_W-1:0]            i_band,
    input  logic [AZ_W-1:0]              i_azimuth,
    input  logic [POL_W-1:0]             i_polar,
    input  logic signed [LEVEL_BITS-1:0] i_level,
    input  logic                         o_valid,
    input  logic                         i_stall,
    input  logic signed [LEVEL_BITS-1:0] o_result_level,
    input  logic                         o_valid_res,
    input  logic                         o_exact_hit,
    input  logic                         i_cfg_valid,
    input  logic                         o_cfg_ready,
    input  logic [STEP_W-1:0]            i_cfg_data,
    output int                           fail_count,
    output int                           answers_due
);

    typedef struct {
        logic signed [LEVEL_BITS-1:0] level;
        logic                         valid_res;
        logic                         exact_hit;
    } answer_t;

    localparam bit OP_WRITE = 1'b0;

    logic signed [LEVEL_BITS-1:0] grid_level [NUM_BANDS_DEF*BAND_SIZE];
    logic                         band_seen  [NUM_BANDS_DEF];
    logic [STEP_W-1:0]            step_reg;
    answer_t                      answer_q[$];

    initial begin
        fail_count  = 0;
        answers_due = 0;
        step_reg    = STEP_W'(STEP_RESET);
        for (int i = 0; i < NUM_BANDS_DEF*BAND_SIZE; i++) grid_level[i] = '0;
        for (int b = 0; b < NUM_BANDS_DEF; b++) band_seen[b] = 1'b0;
    end

    function automatic longint fdiv(input longint a, input longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic longint grid_at(input int b, input int r, input int c);
        return longint'(grid_level[b*BAND_SIZE + r*GRID_COLS + c]);
    endfunction

    // Applies a write or computes the answer of a query; returns 1 when an answer is due.
    function automatic bit lookup_answer(input bit op, input int b, input longint az,
                                         input longint pol, input logic signed [15:0] lvl,
                                         output answer_t ans);
        longint st, s, row, col, fa, fp, r1, c1, a, bb, av, bv, ra, rb, h, l, res;
        bit     in_rng;
        st = longint'(step_reg);
        if (st < MIN_STEP_DEG) st = MIN_STEP_DEG;
        if (st > MAX_STEP) st = MAX_STEP;
        s = st << AFB;
        in_rng = az <= (FULL_TURN << AFB) && pol <= (HALF_TURN << AFB);
        row = 0; col = 0; fa = 0; fp = 0;
        ans.level = '0; ans.valid_res = 1'b0; ans.exact_hit = 1'b0;
        if (in_rng) begin
            row = az / s;
            col = pol / s;
            fa  = az - row * s;
            fp  = pol - col * s;
            if (row * st >= FULL_TURN || row >= GRID_ROWS) row = 0;
            if (col >= GRID_COLS) col = GRID_COLS - 1;
        end
        if (op == OP_WRITE) begin
            if (in_rng && b < NUM_BANDS_DEF) begin
                grid_level[b*BAND_SIZE + int'(row)*GRID_COLS + int'(col)] = lvl;
                band_seen[b] = 1'b1;
            end
            return 1'b0;
        end
        if (!in_rng || b >= NUM_BANDS_DEF || !band_seen[b]) return 1'b1;
        r1 = row + 1;
        c1 = col + 1;
        if (r1 * st >= FULL_TURN || r1 >= GRID_ROWS) r1 = 0;
        if (c1 >= GRID_COLS) c1 = col;
        if (fa == 0 && fp == 0) begin
            res = grid_at(b, int'(row), int'(col));
            ans.exact_hit = 1'b1;
        end else begin
            a  = (s - fp) * grid_at(b, int'(row), int'(col)) + fp * grid_at(b, int'(row), int'(c1));
            bb = (s - fp) * grid_at(b, int'(r1), int'(col)) + fp * grid_at(b, int'(r1), int'(c1));
            av = fdiv(a, s);  ra = a - av * s;
            bv = fdiv(bb, s); rb = bb - bv * s;
            h  = (s - fa) * av + fa * bv;
            l  = (s - fa) * ra + fa * rb;
            res = fdiv(h + (l + (s * s) / 2) / s, s);
        end
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        ans.level     = LEVEL_BITS'(res);
        ans.valid_res = 1'b1;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        answer_t ans;
        answer_t want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) step_reg <= i_cfg_data;
            if (i_valid && !o_stall) begin
                if (lookup_answer(i_operation, int'(i_band), longint'(i_azimuth),
                                  longint'(i_polar), i_level, ans))
                    answer_q.push_back(ans);
            end
            if (o_valid && !i_stall) begin
                if (answer_q.size() == 0) begin
                    $error("result transaction with no query outstanding");
                    fail_count++;
                end else begin
                    want = answer_q.pop_front();
                    if (o_result_level !== want.level) begin
                        $error("result_level expected %0d actual %0d", want.level,
                               o_result_level);
                        fail_count++;
                    end
                    if (o_valid_res !== want.valid_res) begin
                        $error("valid_res expected %0d actual %0d", want.valid_res,
                               o_valid_res);
                        fail_count++;
                    end
                    if (o_exact_hit !== want.exact_hit) begin
                        $error("exact_hit expected %0d actual %0d", want.exact_hit,
                               o_exact_hit);
                        fail_count++;
                    end
                end
            end
            answers_due = answer_q.size();
        end
    end

endmodule

// File: dv/directivity_bilinear_lookup_top_tb.sv
// ----------------------------------------------------------------------------
// directivity_bilinear_lookup_top_tb
// Drives writes and queries through several grid steps with random idling
// on both sides; queries only touch grid points written earlier.
// ----------------------------------------------------------------------------
module directivity_bilinear_lookup_top_tb;
    import dlu_pkg::*;

    localparam bit OP_WRITE = 1'b0;
    localparam bit OP_QUERY = 1'b1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic                         i_operation;
    logic [BAND_W-1:0]            i_band;
    logic [AZ_W-1:0]              i_azimuth;
    logic [POL_W-1:0]             i_polar;
    logic signed [LEVEL_BITS-1:0] i_level;
    logic                         o_valid;
    logic                         i_stall;
    logic signed [LEVEL_BITS-1:0] o_result_level;
    logic                         o_valid_res;
    logic                         o_exact_hit;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [STEP_W-1:0]            i_cfg_data;
    int                           fail_count;
    int                           answers_due;

    int tx_idle;
    int rx_idle;
    int hold_req;
    int cur_step;
    bit filled [NUM_BANDS_DEF*BAND_SIZE];
    bit band_live [NUM_BANDS_DEF];

    directivity_bilinear_lookup_top i_dut (.*);

    directivity_bilinear_lookup_checker i_checker (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: random stall plus long hold-offs on request.
    initial begin
        int hold_cnt;
        int seen_req;
        hold_cnt = 0;
        seen_req = 0;
        i_stall  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != seen_req) begin
                seen_req = hold_req;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_stall = 1'b1;
            end else begin
                i_stall = ($urandom_range(0, 99) < rx_idle);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic void grid_rc(input int az, input int pol, input int st,
                                    output int r, output int c);
        r = az / (st << AFB);
        c = pol / (st << AFB);
        if (r * st >= FULL_TURN || r >= GRID_ROWS) r = 0;
        if (c >= GRID_COLS) c = GRID_COLS - 1;
    endfunction

    task automatic send_item(input bit op, input int band, input int az, input int pol,
                             input int lvl);
        int r;
        int c;
        while ($urandom_range(0, 99) < tx_idle) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_operation = op;
        i_band      = BAND_W'(band);
        i_azimuth   = AZ_W'(az);
        i_polar     = POL_W'(pol);
        i_level     = LEVEL_BITS'(lvl);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        i_valid = 1'b0;
        if (op == OP_WRITE && az <= (FULL_TURN << AFB) && pol <= (HALF_TURN << AFB)) begin
            grid_rc(az, pol, cur_step, r, c);
            filled[band*BAND_SIZE + r*GRID_COLS + c] = 1'b1;
            band_live[band] = 1'b1;
        end
    endtask

    task automatic fill_point(input int band, input int r, input int c);
        if (!filled[band*BAND_SIZE + r*GRID_COLS + c])
            send_item(OP_WRITE, band, (r * cur_step) << AFB, (c * cur_step) << AFB,
                      $urandom_range(0, 65535));
    endtask

    // Query that first writes any corner the lookup would read but that holds no data.
    task automatic query_at(input int band, input int az, input int pol);
        int r0;
        int c0;
        int r1;
        int c1;
        if (band_live[band] && az <= (FULL_TURN << AFB) && pol <= (HALF_TURN << AFB)) begin
            grid_rc(az, pol, cur_step, r0, c0);
            r1 = r0 + 1;
            c1 = c0 + 1;
            if (r1 * cur_step >= FULL_TURN || r1 >= GRID_ROWS) r1 = 0;
            if (c1 >= GRID_COLS) c1 = c0;
            fill_point(band, r0, c0);
            fill_point(band, r0, c1);
            fill_point(band, r1, c0);
            fill_point(band, r1, c1);
        end
        send_item(OP_QUERY, band, az, pol, $urandom_range(0, 65535));
    endtask

    task automatic set_step(input int value);
        while (answers_due != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = STEP_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        cur_step = value;
        if (cur_step < MIN_STEP_DEG) cur_step = MIN_STEP_DEG;
        if (cur_step > MAX_STEP) cur_step = MAX_STEP;
    endtask

    initial begin
        int steps [9] = '{90, 45, 5, 0, 127, 7, 60, 30, 13};
        int pick;
        int band;
        int nbands;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_operation = OP_WRITE;
        i_band      = '0;
        i_azimuth   = '0;
        i_polar     = '0;
        i_level     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        tx_idle     = 7;
        rx_idle     = 62;
        hold_req    = 0;
        cur_step    = STEP_RESET;
        for (int i = 0; i < NUM_BANDS_DEF*BAND_SIZE; i++) filled[i] = 1'b0;
        for (int b = 0; b < NUM_BANDS_DEF; b++) band_live[b] = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part at the reset step of 5 degrees.
        query_at(0, 64, 64);                               // absent band
        send_item(OP_WRITE, 0, 0, 0, -32768);
        send_item(OP_WRITE, 0, 0, 64*5, 32767);
        query_at(0, 0, 0);                                 // exact hit
        query_at(0, 0, 160);                               // tie on the midpoint
        query_at(0, FULL_TURN << AFB, HALF_TURN << AFB);   // wrap and polar edge
        query_at(0, (FULL_TURN << AFB) - 1, (HALF_TURN << AFB) - 1);
        query_at(0, (FULL_TURN << AFB) + 1, 0);            // azimuth out of range
        query_at(0, 0, (HALF_TURN << AFB) + 1);            // polar out of range
        query_at(0, 32767, 16383);
        send_item(OP_WRITE, 1, 32767, 16383, 1234);        // ignored write
        query_at(1, 0, 0);
        send_item(OP_WRITE, 7, FULL_TURN << AFB, HALF_TURN << AFB, -1);
        query_at(7, FULL_TURN << AFB, HALF_TURN << AFB);
        query_at(7, 16384 + 37, 8191);
        query_at(0, 21845, 10922);

        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 3) begin
                tx_idle = 62;
                rx_idle = 7;
            end else if (ph == 6) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            set_step(steps[ph]);
            if (ph == 1 || ph == 7) hold_req++;
            // Bands 6 and 7 stay mostly absent until the later phases.
            nbands = (ph < 5) ? 6 : 8;
            // Small steps need up to four fill writes per query, so fewer of them.
            for (int k = 0; k < ((cur_step < 20) ? 45 : 110); k++) begin
                pick = $urandom_range(0, 99);
                band = $urandom_range(0, nbands - 1);
                if (pick < 70)
                    query_at(band, $urandom_range(0, FULL_TURN << AFB),
                             $urandom_range(0, HALF_TURN << AFB));
                else if (pick < 85)
                    send_item(OP_WRITE, band, $urandom_range(0, FULL_TURN << AFB),
                              $urandom_range(0, HALF_TURN << AFB), $urandom_range(0, 65535));
                else if (pick < 92)
                    query_at($urandom_range(0, 7), $urandom_range(0, 32767),
                             $urandom_range(0, 16383));
                else
                    query_at(band, ($urandom_range(0, FULL_TURN / cur_step) * cur_step) << AFB,
                             ($urandom_range(0, HALF_TURN / cur_step) * cur_step) << AFB);
            end
        end

        while (answers_due != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && answers_due == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/dlu_pkg.sv
hdl/dlu_table.sv
hdl/directivity_bilinear_lookup_top.sv
dv/directivity_bilinear_lookup_checker.sv
dv/directivity_bilinear_lookup_top_tb.sv
